// ===== design/line_and_circle_rasterizer_core_assert.svh =====
// Assertion macros used by the rasterizer engine.
// The macros expect a signal named clk, and LCR_ASSERT also arst_n, in the scope where they are used.
`ifndef LINE_AND_CIRCLE_RASTERIZER_CORE_ASSERT_SVH
`define LINE_AND_CIRCLE_RASTERIZER_CORE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define LCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every rising edge, reset included.
`define LCR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcr_pkg
// Types and constants shared by the line and circle rasterizer.
// ----------------------------------------------------------------------------
package lcr_pkg;

	localparam int PIX_BITS       = 12;
	localparam int CANVAS_BITS    = 11;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 11'd600;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		MODE_LINE   = 2'd0,
		MODE_CIRCLE = 2'd1,
		MODE_STEP   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_IDLE   = 2'd0,
		KIND_LINE   = 2'd1,
		KIND_CIRCLE = 2'd2
	} shape_kind_t;

endpackage

// ===== design/lcr_if.sv =====
// ----------------------------------------------------------------------------
// lcr_if
// Valid/ready channels for command items and for pixel items.
// ----------------------------------------------------------------------------
interface lcr_in_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            mode;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic [COORD_BITS-1:0] radius;

	modport source (output valid, mode, start_x, start_y, end_x, end_y, radius, input ready);
	modport sink (input valid, mode, start_x, start_y, end_x, end_y, radius, output ready);
endinterface

interface lcr_out_if;
	import lcr_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [PIX_BITS-1:0] pixel_x;
	logic signed [PIX_BITS-1:0] pixel_y;
	logic                       on_canvas;
	logic                       last_pixel;

	modport source (output valid, pixel_x, pixel_y, on_canvas, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, on_canvas, last_pixel, output ready);
endinterface

// ===== design/lcr_in_stage.sv =====
// ----------------------------------------------------------------------------
// lcr_in_stage
// Input register: holds one command item in front of the rasterizer engine.
// ----------------------------------------------------------------------------
module lcr_in_stage (
	input logic   clk,
	input logic   arst_n,
	lcr_in_if.sink   up,
	lcr_in_if.source dn
);
	logic valid_q;

	assign up.ready = !valid_q || dn.ready;
	assign dn.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up.ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up.valid && up.ready) begin
			dn.mode    <= up.mode;
			dn.start_x <= up.start_x;
			dn.start_y <= up.start_y;
			dn.end_x   <= up.end_x;
			dn.end_y   <= up.end_y;
			dn.radius  <= up.radius;
		end
	end

endmodule

// ===== design/lcr_engine.sv =====
// ----------------------------------------------------------------------------
// lcr_engine
// Shape state, one Bresenham step or one midpoint-circle mirror point per step item, the
// canvas registers and the pixel result register.
// ----------------------------------------------------------------------------
module lcr_engine #(
	parameter int COORD_BITS = 10
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_wr_en,
	input logic [lcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [lcr_pkg::CANVAS_BITS-1:0]    cfg_data,
	lcr_in_if.sink                            item,
	lcr_out_if.source                         pixel
);
	import lcr_pkg::*;

	localparam int N   = COORD_BITS;
	localparam int CW  = N + 2;                          // circle u, v and offsets
	localparam int LEW = N + 3;                          // line error term
	localparam int CEW = N + 4;                          // circle error term
	localparam int XW  = N + 6;                          // circle update arithmetic
	localparam int PW  = (CW > PIX_BITS) ? CW : PIX_BITS; // pixel arithmetic

	localparam logic signed [XW-1:0]  ONE_X = XW'(1);
	localparam logic signed [CEW-1:0] ONE_C = CEW'(1);

	// Configuration registers.
	logic [CANVAS_BITS-1:0] canvas_w_q, canvas_h_q;

	// Shape state.
	shape_kind_t            kind_q, kind_d;
	logic [N-1:0]           cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [N-1:0]           cur_x_d, cur_y_d, tgt_x_d, tgt_y_d;
	logic [N-1:0]           span_x_q, span_y_q, span_x_d, span_y_d;
	logic [1:0]             signs_q, signs_d;
	logic                   x_major_q, x_major_d;
	logic signed [LEW-1:0]  line_err_q, line_err_d;
	logic signed [CW-1:0]   cu_q, cv_q, cu_d, cv_d;
	logic signed [CEW-1:0]  cerr_q, cerr_d;
	logic [2:0]             mirror_q, mirror_d;

	// Result register.
	logic                       out_valid_q;
	logic signed [PIX_BITS-1:0] pix_x_q, pix_y_q;
	logic                       on_canvas_q, last_q;

	logic take, produces, step_last;

	// Line load.
	logic signed [N:0]     ld_dx, ld_dy, ld_ndx, ld_ndy;
	logic [N-1:0]          ld_span_x, ld_span_y;
	logic                  ld_x_major;
	logic signed [LEW-1:0] ld_err;
	logic                  ld_idle;

	// Line step.
	logic [N-1:0]          maj_span, min_span;
	logic signed [LEW-1:0] ln_e1, ln_e2;
	logic                  ln_minor;
	logic [N-1:0]          ln_nx, ln_ny;
	logic                  ln_last;

	// Circle step.
	logic signed [CW-1:0]  off_x, off_y;
	logic signed [XW-1:0]  err_w, u_w, v_w, v1, err1, u1, err2;
	logic                  c_cond, c_last;
	logic signed [CEW-1:0] r_c;

	// Pixel.
	logic signed [PW-1:0]  px, py;
	logic                  on_canvas;

	assign produces   = (item.mode == MODE_STEP) && (kind_q != KIND_IDLE);
	assign item.ready = !produces || !out_valid_q || pixel.ready;
	assign take       = item.valid && item.ready;

	always_comb begin
		// Line set-up: spans, directions and major axis.
		ld_dx      = $signed({1'b0, item.end_x}) - $signed({1'b0, item.start_x});
		ld_dy      = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
		ld_ndx     = -ld_dx;
		ld_ndy     = -ld_dy;
		ld_span_x  = ld_dx[N] ? ld_ndx[N-1:0] : ld_dx[N-1:0];
		ld_span_y  = ld_dy[N] ? ld_ndy[N-1:0] : ld_dy[N-1:0];
		ld_x_major = ld_span_x > ld_span_y;
		ld_err     = ld_x_major ? -$signed({3'b000, ld_span_x}) : -$signed({3'b000, ld_span_y});
		ld_idle    = ld_x_major ? (item.start_x == item.end_x) : (item.start_y == item.end_y);

		// Bresenham step.
		maj_span = x_major_q ? span_x_q : span_y_q;
		min_span = x_major_q ? span_y_q : span_x_q;
		ln_e1    = line_err_q + $signed({2'b00, min_span, 1'b0});
		ln_minor = ln_e1 > 0;
		ln_e2    = ln_minor ? ln_e1 - $signed({2'b00, maj_span, 1'b0}) : ln_e1;
		ln_nx    = signs_q[0] ? cur_x_q - N'(1) : cur_x_q + N'(1);
		ln_ny    = signs_q[1] ? cur_y_q - N'(1) : cur_y_q + N'(1);
		ln_last  = x_major_q ? (ln_nx == tgt_x_q) : (ln_ny == tgt_y_q);

		// The eight octant mirrors of the current (u, v).
		case (mirror_q)
			3'd0:    begin off_x = cu_q;  off_y = cv_q;  end
			3'd1:    begin off_x = -cu_q; off_y = cv_q;  end
			3'd2:    begin off_x = -cu_q; off_y = -cv_q; end
			3'd3:    begin off_x = cu_q;  off_y = -cv_q; end
			3'd4:    begin off_x = cv_q;  off_y = cu_q;  end
			3'd5:    begin off_x = -cv_q; off_y = cu_q;  end
			3'd6:    begin off_x = -cv_q; off_y = -cu_q; end
			default: begin off_x = cv_q;  off_y = -cu_q; end
		endcase

		// Midpoint update, used after the eighth mirror.
		err_w  = XW'(cerr_q);
		u_w    = XW'(cu_q);
		v_w    = XW'(cv_q);
		c_cond = (err_w + err_w) > (ONE_X - (v_w + v_w));
		v1     = c_cond ? v_w - ONE_X : v_w;
		err1   = c_cond ? err_w - (v1 + v1 - ONE_X) : err_w;
		u1     = u_w + ONE_X;
		err2   = err1 + u1 + u1 + ONE_X;
		c_last = u1 > v1;
		r_c    = CEW'(item.radius);

		if (kind_q == KIND_LINE) begin
			px        = PW'(cur_x_q);
			py        = PW'(cur_y_q);
			step_last = ln_last;
		end else begin
			px        = PW'(cur_x_q) + PW'(off_x);
			py        = PW'(cur_y_q) + PW'(off_y);
			step_last = (mirror_q == 3'd7) && c_last;
		end
		on_canvas = !px[PW-1] && !py[PW-1] &&
		            (px < PW'(canvas_w_q)) && (py < PW'(canvas_h_q));
	end

	always_comb begin
		kind_d     = kind_q;
		cur_x_d    = cur_x_q;
		cur_y_d    = cur_y_q;
		tgt_x_d    = tgt_x_q;
		tgt_y_d    = tgt_y_q;
		span_x_d   = span_x_q;
		span_y_d   = span_y_q;
		signs_d    = signs_q;
		x_major_d  = x_major_q;
		line_err_d = line_err_q;
		cu_d       = cu_q;
		cv_d       = cv_q;
		cerr_d     = cerr_q;
		mirror_d   = mirror_q;
		if (take) begin
			case (item.mode)
				MODE_LINE: begin
					cur_x_d    = item.start_x;
					cur_y_d    = item.start_y;
					tgt_x_d    = item.end_x;
					tgt_y_d    = item.end_y;
					span_x_d   = ld_span_x;
					span_y_d   = ld_span_y;
					signs_d    = {ld_dy[N] || (ld_dy == '0), ld_dx[N] || (ld_dx == '0)};
					x_major_d  = ld_x_major;
					line_err_d = ld_err;
					mirror_d   = 3'd0;
					kind_d     = ld_idle ? KIND_IDLE : KIND_LINE;
				end
				MODE_CIRCLE: begin
					cur_x_d  = item.start_x;
					cur_y_d  = item.start_y;
					cu_d     = '0;
					cv_d     = $signed({2'b00, item.radius});
					cerr_d   = (ONE_C - r_c) <<< 1;
					mirror_d = 3'd0;
					kind_d   = KIND_CIRCLE;
				end
				MODE_STEP: begin
					if (kind_q == KIND_LINE) begin
						line_err_d = ln_e2;
						if (x_major_q) begin
							cur_x_d = ln_nx;
							cur_y_d = ln_minor ? ln_ny : cur_y_q;
						end else begin
							cur_y_d = ln_ny;
							cur_x_d = ln_minor ? ln_nx : cur_x_q;
						end
						if (ln_last) begin
							kind_d = KIND_IDLE;
						end
					end else if (kind_q == KIND_CIRCLE) begin
						if (mirror_q == 3'd7) begin
							cu_d     = CW'(u1);
							cv_d     = CW'(v1);
							cerr_d   = CEW'(err2);
							mirror_d = 3'd0;
							if (c_last) begin
								kind_d = KIND_IDLE;
							end
						end else begin
							mirror_d = mirror_q + 3'd1;
						end
					end
				end
				default: begin
					kind_d = kind_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_IDLE;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			tgt_x_q    <= '0;
			tgt_y_q    <= '0;
			span_x_q   <= '0;
			span_y_q   <= '0;
			signs_q    <= '0;
			x_major_q  <= 1'b0;
			line_err_q <= '0;
			cu_q       <= '0;
			cv_q       <= '0;
			cerr_q     <= '0;
			mirror_q   <= '0;
		end else begin
			kind_q     <= kind_d;
			cur_x_q    <= cur_x_d;
			cur_y_q    <= cur_y_d;
			tgt_x_q    <= tgt_x_d;
			tgt_y_q    <= tgt_y_d;
			span_x_q   <= span_x_d;
			span_y_q   <= span_y_d;
			signs_q    <= signs_d;
			x_major_q  <= x_major_d;
			line_err_q <= line_err_d;
			cu_q       <= cu_d;
			cv_q       <= cv_d;
			cerr_q     <= cerr_d;
			mirror_q   <= mirror_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= CANVAS_RESET;
			canvas_h_q <= CANVAS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data;
				REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data;
				default: begin
					canvas_w_q <= canvas_w_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && produces) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produces) begin
			pix_x_q     <= px[PIX_BITS-1:0];
			pix_y_q     <= py[PIX_BITS-1:0];
			on_canvas_q <= on_canvas;
			last_q      <= step_last;
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.pixel_x    = pix_x_q;
	assign pixel.pixel_y    = pix_y_q;
	assign pixel.on_canvas  = on_canvas_q;
	assign pixel.last_pixel = last_q;

	`include "line_and_circle_rasterizer_core_assert.svh"

	`LCR_ASSERT(a_result_from_step, $rose(out_valid_q) |-> $past(take && produces), "result without a step")
	`LCR_ASSERT(a_last_goes_idle, (take && produces && step_last) |=> (kind_q == KIND_IDLE), "shape still active after its last pixel")
	`LCR_ASSERT_ALWAYS(a_mirror_in_circle, (mirror_q != 3'd0) |-> (kind_q == KIND_CIRCLE), "mirror index outside a circle")
	`LCR_ASSERT(a_line_err_bound, (kind_q == KIND_LINE) |-> (line_err_q[LEW-1] || (line_err_q == '0)), "line error term positive between steps")

endmodule

// ===== design/line_and_circle_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// line_and_circle_rasterizer_core
// Bresenham line and midpoint circle rasterizer, one pixel per step item while a shape is active.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  item_in    in   valid / ready    mode, start_x, start_y, end_x, end_y, radius
//  pixel_out  out  valid / ready    pixel_x, pixel_y, on_canvas, last_pixel
//  cfg        in   cfg_wr_en        cfg_index, cfg_data
//
// One item is taken per cycle unless a full result register stalls it; a step's
// pixel passes the input register, then the result register, before it leaves.
// The rate is set by the combinational error update of the shape state.
// Reset leaves no shape active and both canvas registers at 600.
// A full result register that is not being taken stalls only step items that
// give a pixel; loads and idle steps flow on.
// ----------------------------------------------------------------------------
module line_and_circle_rasterizer_core #(
	parameter int COORD_BITS = 10
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_wr_en,
	input logic [lcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [lcr_pkg::CANVAS_BITS-1:0]    cfg_data,
	lcr_in_if.sink                            item_in,
	lcr_out_if.source                         pixel_out
);
	import lcr_pkg::*;

	lcr_in_if #(.COORD_BITS(COORD_BITS)) stage_if ();

	lcr_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (item_in),
		.dn     (stage_if)
	);

	lcr_engine #(.COORD_BITS(COORD_BITS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (stage_if),
		.pixel     (pixel_out)
	);

endmodule

// ===== test/line_and_circle_rasterizer_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_and_circle_rasterizer_core_checker
// Watches the command, pixel and register ports of the rasterizer, keeps its
// own copy of the shape state and compares every pixel item in order.
// ----------------------------------------------------------------------------
module line_and_circle_rasterizer_core_checker #(
	parameter int COORD_BITS = 10
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_wr_en,
	input logic [lcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [lcr_pkg::CANVAS_BITS-1:0]    cfg_data,
	lcr_in_if                                 cmd,
	lcr_out_if                                pix,
	output int                                fail_count,
	output int                                pending_pixels
);
	import lcr_pkg::*;

	localparam int LINE_ERR_BITS = 12;
	localparam int ARC_BITS      = 11;
	localparam int ARC_ERR_BITS  = 14;

	typedef struct packed {
		logic signed [PIX_BITS-1:0] x;
		logic signed [PIX_BITS-1:0] y;
		logic                       on_canvas;
		logic                       last;
	} pixel_t;

	logic [CANVAS_BITS-1:0]           canvas_w;
	logic [CANVAS_BITS-1:0]           canvas_h;
	shape_kind_t                      active_shape;
	logic [COORD_BITS-1:0]            pen_x;
	logic [COORD_BITS-1:0]            pen_y;
	logic [COORD_BITS-1:0]            goal_x;
	logic [COORD_BITS-1:0]            goal_y;
	logic [COORD_BITS-1:0]            run_x;
	logic [COORD_BITS-1:0]            run_y;
	logic [1:0]                       falling;
	logic                             x_major;
	logic signed [LINE_ERR_BITS-1:0]  line_err;
	logic signed [ARC_BITS-1:0]       arc_u;
	logic signed [ARC_BITS-1:0]       arc_v;
	logic signed [ARC_ERR_BITS-1:0]   arc_err;
	logic [2:0]                       octant;

	pixel_t expected_pixels[$];
	pixel_t got;
	pixel_t want;

	function automatic void clear_predictor();
		canvas_w = CANVAS_RESET;
		canvas_h = CANVAS_RESET;
		active_shape = KIND_IDLE;
		pen_x = '0;
		pen_y = '0;
		goal_x = '0;
		goal_y = '0;
		run_x = '0;
		run_y = '0;
		falling = '0;
		x_major = 1'b0;
		line_err = '0;
		arc_u = '0;
		arc_v = '0;
		arc_err = '0;
		octant = '0;
		expected_pixels.delete();
		pending_pixels = 0;
	endfunction

	function automatic pixel_t plot(int px, int py, bit last);
		pixel_t p;
		p.x = PIX_BITS'(px);
		p.y = PIX_BITS'(py);
		p.on_canvas = px >= 0 && py >= 0 && px < int'(canvas_w) && py < int'(canvas_h);
		p.last = last;
		return p;
	endfunction

	function automatic void load_line(logic [COORD_BITS-1:0] sx, sy, ex, ey);
		int dx;
		int dy;
		int ax;
		int ay;
		dx = int'(ex) - int'(sx);
		dy = int'(ey) - int'(sy);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		pen_x = sx;
		pen_y = sy;
		goal_x = ex;
		goal_y = ey;
		run_x = COORD_BITS'(ax);
		run_y = COORD_BITS'(ay);
		falling = {dy <= 0, dx <= 0};
		x_major = ax > ay;
		line_err = LINE_ERR_BITS'(x_major ? -ax : -ay);
		active_shape = (x_major ? sx == ex : sy == ey) ? KIND_IDLE : KIND_LINE;
	endfunction

	function automatic void load_circle(logic [COORD_BITS-1:0] cx, cy, r);
		pen_x = cx;
		pen_y = cy;
		arc_u = '0;
		arc_v = ARC_BITS'(int'(r));
		arc_err = ARC_ERR_BITS'(2 * (1 - int'(r)));
		octant = '0;
		active_shape = KIND_CIRCLE;
	endfunction

	// One Bresenham step: the pen position before the move is the pixel drawn.
	function automatic pixel_t trace_line();
		int  px;
		int  py;
		int  step_x;
		int  step_y;
		int  e;
		bit  last;
		px = int'(pen_x);
		py = int'(pen_y);
		step_x = falling[0] ? -1 : 1;
		step_y = falling[1] ? -1 : 1;
		e = int'(line_err);
		if (x_major) begin
			e += 2 * int'(run_y);
			if (e > 0) begin
				pen_y = COORD_BITS'(py + step_y);
				e -= 2 * int'(run_x);
			end
			pen_x = COORD_BITS'(px + step_x);
			last = pen_x == goal_x;
		end else begin
			e += 2 * int'(run_x);
			if (e > 0) begin
				pen_x = COORD_BITS'(px + step_x);
				e -= 2 * int'(run_y);
			end
			pen_y = COORD_BITS'(py + step_y);
			last = pen_y == goal_y;
		end
		line_err = LINE_ERR_BITS'(e);
		if (last)
			active_shape = KIND_IDLE;
		return plot(px, py, last);
	endfunction

	// Each midpoint iteration is spread over eight items, one per mirror image;
	// the decision variable moves on only with the eighth.
	function automatic pixel_t trace_circle();
		int u;
		int v;
		int e;
		int dx;
		int dy;
		bit last;
		u = int'(arc_u);
		v = int'(arc_v);
		last = 1'b0;
		case (octant)
			3'd0: begin dx = u;  dy = v;  end
			3'd1: begin dx = -u; dy = v;  end
			3'd2: begin dx = -u; dy = -v; end
			3'd3: begin dx = u;  dy = -v; end
			3'd4: begin dx = v;  dy = u;  end
			3'd5: begin dx = -v; dy = u;  end
			3'd6: begin dx = -v; dy = -u; end
			default: begin dx = v; dy = -u; end
		endcase
		if (octant == 3'd7) begin
			e = int'(arc_err);
			if (2 * e > 1 - 2 * v) begin
				v -= 1;
				e -= 2 * v - 1;
			end
			u += 1;
			e += 2 * u + 1;
			if (u > v) begin
				last = 1'b1;
				active_shape = KIND_IDLE;
			end
			arc_u = ARC_BITS'(u);
			arc_v = ARC_BITS'(v);
			arc_err = ARC_ERR_BITS'(e);
			octant = '0;
		end else begin
			octant = octant + 3'd1;
		end
		return plot(int'(pen_x) + dx, int'(pen_y) + dy, last);
	endfunction

	initial begin
		fail_count = 0;
		clear_predictor();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_predictor();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CANVAS_WIDTH: canvas_w = cfg_data;
					REG_CANVAS_HEIGHT: canvas_h = cfg_data;
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				got.x = pix.pixel_x;
				got.y = pix.pixel_y;
				got.on_canvas = pix.on_canvas;
				got.last = pix.last_pixel;
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel x=%0d y=%0d on=%0b last=%0b",
						$time, got.x, got.y, got.on_canvas, got.last);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						$display("%0t: pixel expected x=%0d y=%0d on=%0b last=%0b, got x=%0d y=%0d on=%0b last=%0b",
							$time, want.x, want.y, want.on_canvas, want.last,
							got.x, got.y, got.on_canvas, got.last);
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				case (cmd.mode)
					MODE_LINE: load_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y);
					MODE_CIRCLE: load_circle(cmd.start_x, cmd.start_y, cmd.radius);
					MODE_STEP: begin
						if (active_shape == KIND_LINE)
							expected_pixels.push_back(trace_line());
						else if (active_shape == KIND_CIRCLE)
							expected_pixels.push_back(trace_circle());
					end
					default: ;
				endcase
			end
			pending_pixels = expected_pixels.size();
		end
	end

endmodule

// ===== test/line_and_circle_rasterizer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_and_circle_rasterizer_core_tb
// Drives line, circle and step items into the rasterizer under several canvas
// sizes, with random gaps and back-pressure; the checker judges every pixel.
// ----------------------------------------------------------------------------
module line_and_circle_rasterizer_core_tb;
	import lcr_pkg::*;

	localparam int COORD_BITS       = 10;
	localparam int MAX_COORD        = (1 << COORD_BITS) - 1;
	localparam int SETTLE_CYCLES    = 6;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int RUN_LIMIT_NS     = 2000000;

	// The largest coordinate, at the width of the item fields.
	localparam logic [COORD_BITS-1:0] FAR_COORD = '1;

	// The mode code that the block leaves unused.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CANVAS_BITS-1:0]    cfg_data;
	int                        fail_count;
	int                        pending_pixels;
	bit                        idling_on = 1'b1;
	bit                        hold_pixel_sink = 1'b0;

	lcr_in_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
	lcr_out_if pix_ch ();

	line_and_circle_rasterizer_core #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_in   (cmd_ch),
		.pixel_out (pix_ch)
	);

	line_and_circle_rasterizer_core_checker #(
		.COORD_BITS(COORD_BITS)
	) pixel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd_ch),
		.pix            (pix_ch),
		.fail_count     (fail_count),
		.pending_pixels (pending_pixels)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("line_and_circle_rasterizer_core verification failed");
		$finish;
	end

	// Pixel receiver: short random stalls, or one long hold-off when asked.
	initial begin
		pix_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_pixel_sink) begin
				hold_pixel_sink = 1'b0;
				pix_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				pix_ch.ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				pix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				pix_ch.ready <= 1'b1;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [COORD_BITS-1:0] rand_coord();
		return COORD_BITS'($urandom_range(0, MAX_COORD));
	endfunction

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : (v > MAX_COORD) ? MAX_COORD : v;
	endfunction

	// Offers one item and returns at the clock edge that accepts it.
	task automatic send_item(input logic [1:0] mode,
			input logic [COORD_BITS-1:0] sx, sy, ex, ey, r);
		int gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= mode;
		cmd_ch.start_x <= sx;
		cmd_ch.start_y <= sy;
		cmd_ch.end_x <= ex;
		cmd_ch.end_y <= ey;
		cmd_ch.radius <= r;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	task automatic step_shape(input int n);
		repeat (n) send_item(MODE_STEP, rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord());
	endtask

	// Stops offering items until every pixel is in and loads have passed through.
	task automatic drain_pixels();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		wait (pending_pixels == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_canvas(input logic [CANVAS_BITS-1:0] w, h);
		drain_pixels();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CANVAS_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= REG_CANVAS_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly complete shapes of random size and place, some dropped part way
	// by the next load, some long ones cut short, and a little noise.
	task automatic run_random_phase(input int budget);
		int sent;
		int pick;
		int n;
		int x0;
		int y0;
		int x1;
		int y1;
		int r;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			x0 = $urandom_range(0, MAX_COORD);
			y0 = $urandom_range(0, MAX_COORD);
			if (pick == 0) begin
				send_item(MODE_UNUSED, COORD_BITS'(x0), COORD_BITS'(y0), rand_coord(),
					rand_coord(), rand_coord());
			end else if (pick < 12) begin
				if (pick == 1) begin
					x1 = rand_coord();
					y1 = rand_coord();
					n = $urandom_range(1, 30);
				end else begin
					x1 = clamp_coord(x0 + int'($urandom_range(0, 24)) - 12);
					y1 = clamp_coord(y0 + int'($urandom_range(0, 24)) - 12);
					n = (x1 > x0) ? x1 - x0 : x0 - x1;
					if (((y1 > y0) ? y1 - y0 : y0 - y1) > n)
						n = (y1 > y0) ? y1 - y0 : y0 - y1;
					n += $urandom_range(0, 2);
					if ($urandom_range(0, 7) == 0)
						n = n / 2;
				end
				send_item(MODE_LINE, COORD_BITS'(x0), COORD_BITS'(y0), COORD_BITS'(x1),
					COORD_BITS'(y1), rand_coord());
				step_shape(n);
				sent += n + 1;
			end else begin
				if (pick == 12) begin
					r = rand_coord();
					n = $urandom_range(1, 40);
				end else begin
					r = $urandom_range(0, 8);
					n = 8 * (r * 3 / 4 + 2);
					if ($urandom_range(0, 7) == 0)
						n = n / 2;
				end
				send_item(MODE_CIRCLE, COORD_BITS'(x0), COORD_BITS'(y0), rand_coord(),
					rand_coord(), COORD_BITS'(r));
				step_shape(n);
				sent += n + 1;
			end
			if ($urandom_range(0, 15) == 0)
				drain_pixels();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_CANVAS_WIDTH;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_STEP;
		cmd_ch.start_x = '0;
		cmd_ch.start_y = '0;
		cmd_ch.end_x = '0;
		cmd_ch.end_y = '0;
		cmd_ch.radius = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A step with nothing loaded and the unused mode both give nothing.
		send_item(MODE_STEP, '0, '0, '0, '0, '0);
		send_item(MODE_UNUSED, FAR_COORD, FAR_COORD, FAR_COORD, FAR_COORD, FAR_COORD);
		// A line whose ends coincide draws nothing.
		send_item(MODE_LINE, 10'd5, 10'd5, 10'd5, 10'd5, '0);
		step_shape(1);
		// Shallow rising line: three pixels, the end one left out.
		send_item(MODE_LINE, '0, '0, 10'd3, 10'd1, FAR_COORD);
		step_shape(3);
		// Steep falling line from the far corner, dropped by the next load.
		send_item(MODE_LINE, FAR_COORD, FAR_COORD, FAR_COORD - COORD_BITS'(1),
			FAR_COORD - COORD_BITS'(3), '0);
		step_shape(2);
		// Zero radius: eight pixels, all on the centre.
		send_item(MODE_CIRCLE, '0, '0, FAR_COORD, FAR_COORD, '0);
		step_shape(8);
		// Largest circle, mostly off canvas, given up for a full-span diagonal.
		send_item(MODE_CIRCLE, FAR_COORD, '0, '0, '0, FAR_COORD);
		step_shape(3);
		send_item(MODE_LINE, '0, FAR_COORD, FAR_COORD, '0, '0);
		step_shape(2);

		write_canvas(11'd1024, 11'd1024);
		// The receiver holds off while steps keep coming, so the block backs up.
		@(posedge clk);
		hold_pixel_sink = 1'b1;
		send_item(MODE_CIRCLE, 10'd512, 10'd512, rand_coord(), rand_coord(), 10'd5);
		step_shape(48);
		run_random_phase(170);

		write_canvas(11'd0, 11'd0);
		run_random_phase(100);

		write_canvas(11'd1, 11'd2047);
		run_random_phase(170);

		write_canvas(11'd2047, 11'd1);
		run_random_phase(170);

		write_canvas(CANVAS_BITS'($urandom_range(1, 1024)),
			CANVAS_BITS'($urandom_range(1, 1024)));
		idling_on = 1'b0;
		run_random_phase(200);

		drain_pixels();
		if (fail_count == 0 && pending_pixels == 0)
			$display("line_and_circle_rasterizer_core verification clean");
		else
			$display("line_and_circle_rasterizer_core verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/lcr_pkg.sv
design/lcr_if.sv
design/lcr_in_stage.sv
design/lcr_engine.sv
design/line_and_circle_rasterizer_core.sv
test/line_and_circle_rasterizer_core_checker.sv
test/line_and_circle_rasterizer_core_tb.sv
